// ===== rtl/hrs_pkg.sv =====
// shared types, constants and helpers for the row scan driver
`timescale 1ns / 1ps
package hrs_pkg;

  localparam int unsigned COL_W      = 6;
  localparam int unsigned ROW_W      = 5;
  localparam int unsigned CH_W       = 5;
  localparam int unsigned COLOR_W    = 3 * CH_W;
  localparam int unsigned SCAN_ROW_W = 4;
  localparam int unsigned HALF_ROWS  = 16;

  localparam logic [SCAN_ROW_W-1:0] SCAN_ROW_RST = 4'd15;
  localparam logic [CH_W-1:0]       PLANE_RST    = 5'd30;
  localparam logic [CH_W-1:0]       PLANE_LAST   = 5'd30;

  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_TICK  = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_SCAN  = 3'b100
  } state_e;

  typedef struct packed {
    logic clr_en;
    logic wr_en;
    logic tick;
    logic issue;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic issue_last;
    logic s1_busy;
    logic stage_free;
  } dp_status_t;

  function automatic logic [CH_W-1:0] rev5(input logic [CH_W-1:0] v);
    return {v[0], v[1], v[2], v[3], v[4]};
  endfunction

endpackage

// ===== rtl/hrs_if.sv =====
// valid/ready channel interfaces for pixel/tick input and column output beats
`timescale 1ns / 1ps
interface hrs_in_if
  import hrs_pkg::*;
();
  logic               valid;
  logic               ready;
  logic               action;
  logic [COL_W-1:0]   column;
  logic [ROW_W-1:0]   row;
  logic [COLOR_W-1:0] pixel_color;

  modport source (output valid, action, column, row, pixel_color, input ready);
  modport sink   (input valid, action, column, row, pixel_color, output ready);
endinterface

interface hrs_out_if
  import hrs_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic                  upper_red;
  logic                  upper_green;
  logic                  upper_blue;
  logic                  lower_red;
  logic                  lower_green;
  logic                  lower_blue;
  logic [COL_W-1:0]      shift_column;
  logic                  latch_last;
  logic [SCAN_ROW_W-1:0] row_address;

  modport source (output valid, upper_red, upper_green, upper_blue, lower_red,
                  lower_green, lower_blue, shift_column, latch_last, row_address,
                  input ready);
  modport sink   (input valid, upper_red, upper_green, upper_blue, lower_red,
                  lower_green, lower_blue, shift_column, latch_last, row_address,
                  output ready);
endinterface

// ===== rtl/hrs_ram.sv =====
// generic single write port ram with registered read
`timescale 1ns / 1ps
module hrs_ram #(
  parameter int unsigned WIDTH = 15,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/hrs_ctrl.sv =====
// control state machine: clearing pass, item intake and column issue
`timescale 1ns / 1ps
module hrs_ctrl
  import hrs_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_action_i,
  output logic       in_ready_o,
  input  dp_status_t status_i,
  output ctrl_cmd_t  cmd_o
);

  state_e state_q, state_d;
  logic   accept;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    accept     = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_en = 1'b1;
        if (status_i.clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        // wait until the last column has been thresholded
        in_ready_o = !status_i.s1_busy;
        accept     = in_valid_i && in_ready_o;
        if (accept) begin
          if (in_action_i == ACT_TICK) begin
            cmd_o.tick = 1'b1;
            state_d    = ST_SCAN;
          end else begin
            cmd_o.wr_en = 1'b1;
          end
        end
      end
      ST_SCAN: begin
        cmd_o.issue = status_i.stage_free;
        if (cmd_o.issue && status_i.issue_last) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== rtl/hrs_dpath.sv =====
// datapath: frame store halves, scan/plane counters, read stage and output register
`timescale 1ns / 1ps
module hrs_dpath
  import hrs_pkg::*;
#(
  parameter int unsigned PANEL_WIDTH = 64
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  ctrl_cmd_t             cmd_i,
  output dp_status_t            status_o,
  input  logic [COL_W-1:0]      column_i,
  input  logic [ROW_W-1:0]      row_i,
  input  logic [COLOR_W-1:0]    pixel_color_i,
  input  logic                  out_ready_i,
  output logic                  out_valid_o,
  output logic                  upper_red_o,
  output logic                  upper_green_o,
  output logic                  upper_blue_o,
  output logic                  lower_red_o,
  output logic                  lower_green_o,
  output logic                  lower_blue_o,
  output logic [COL_W-1:0]      shift_column_o,
  output logic                  latch_last_o,
  output logic [SCAN_ROW_W-1:0] row_address_o
);

  localparam int unsigned COL_AW     = (PANEL_WIDTH > 1) ? $clog2(PANEL_WIDTH) : 1;
  localparam int unsigned RAM_AW     = SCAN_ROW_W + COL_AW;
  localparam int unsigned HALF_DEPTH = HALF_ROWS << COL_AW;

  logic [SCAN_ROW_W-1:0] scan_row_q, scan_row_d;
  logic [CH_W-1:0]       plane_q, plane_d;
  logic [CH_W-1:0]       thr;
  logic [COL_AW-1:0]     col_q, col_d;
  logic [RAM_AW-1:0]     clr_q;

  logic                  s1_valid_q, s1_valid_d;
  logic [COL_AW-1:0]     s1_col_q;
  logic                  s1_last_q;
  logic                  s1_adv;
  logic                  out_valid_q, out_valid_d;

  logic [RAM_AW-1:0]     waddr, raddr;
  logic [COLOR_W-1:0]    wdata;
  logic                  col_ok;
  logic                  we_up, we_lo;
  logic [COLOR_W-1:0]    up_pix, lo_pix;

  logic [2:0]            up_bits_q, lo_bits_q;
  logic [COL_W-1:0]      shift_col_q;
  logic                  last_q;
  logic [SCAN_ROW_W-1:0] row_addr_q;

  // ---------------- frame store write side ----------------
  assign col_ok = {1'b0, column_i} < (COL_W + 1)'(PANEL_WIDTH);

  always_comb begin
    if (cmd_i.clr_en) begin
      waddr = clr_q;
      wdata = '0;
      we_up = 1'b1;
      we_lo = 1'b1;
    end else begin
      waddr = {row_i[SCAN_ROW_W-1:0], column_i[COL_AW-1:0]};
      wdata = pixel_color_i;
      we_up = cmd_i.wr_en && col_ok && !row_i[ROW_W-1];
      we_lo = cmd_i.wr_en && col_ok &&  row_i[ROW_W-1];
    end
  end

  assign raddr = {scan_row_q, col_q};

  hrs_ram #(.WIDTH(COLOR_W), .DEPTH(HALF_DEPTH)) u_ram_upper (
    .clk_i   (clk_i),
    .we_i    (we_up),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (cmd_i.issue),
    .raddr_i (raddr),
    .rdata_o (up_pix)
  );

  hrs_ram #(.WIDTH(COLOR_W), .DEPTH(HALF_DEPTH)) u_ram_lower (
    .clk_i   (clk_i),
    .we_i    (we_lo),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (cmd_i.issue),
    .raddr_i (raddr),
    .rdata_o (lo_pix)
  );

  // ---------------- scan counters ----------------
  always_comb begin
    scan_row_d = scan_row_q;
    plane_d    = plane_q;
    col_d      = col_q;
    if (cmd_i.tick) begin
      scan_row_d = scan_row_q + 1'b1;
      col_d      = '0;
      // plane advances once per frame, wrapping after PLANE_LAST
      if (scan_row_d == '0) begin
        plane_d = (plane_q == PLANE_LAST) ? '0 : plane_q + 1'b1;
      end
    end else if (cmd_i.issue) begin
      col_d = col_q + 1'b1;
    end
  end

  assign thr = rev5(plane_q);

  // ---------------- read stage and output register ----------------
  assign s1_adv = s1_valid_q && (!out_valid_q || out_ready_i);

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (cmd_i.issue) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (s1_adv) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_row_q  <= SCAN_ROW_RST;
      plane_q     <= PLANE_RST;
      col_q       <= '0;
      clr_q       <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      scan_row_q  <= scan_row_d;
      plane_q     <= plane_d;
      col_q       <= col_d;
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (cmd_i.clr_en) begin
        clr_q <= clr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.issue) begin
      s1_col_q  <= col_q;
      s1_last_q <= (col_q == COL_AW'(PANEL_WIDTH - 1));
    end
    if (s1_adv) begin
      up_bits_q   <= {up_pix[14:10] > thr, up_pix[9:5] > thr, up_pix[4:0] > thr};
      lo_bits_q   <= {lo_pix[14:10] > thr, lo_pix[9:5] > thr, lo_pix[4:0] > thr};
      shift_col_q <= COL_W'(s1_col_q);
      last_q      <= s1_last_q;
      row_addr_q  <= s1_last_q ? scan_row_q : '0;
    end
  end

  assign status_o.clr_last   = &clr_q;
  assign status_o.issue_last = (col_q == COL_AW'(PANEL_WIDTH - 1));
  assign status_o.s1_busy    = s1_valid_q;
  assign status_o.stage_free = !s1_valid_q || s1_adv;

  assign out_valid_o    = out_valid_q;
  assign upper_red_o    = up_bits_q[0];
  assign upper_green_o  = up_bits_q[1];
  assign upper_blue_o   = up_bits_q[2];
  assign lower_red_o    = lo_bits_q[0];
  assign lower_green_o  = lo_bits_q[1];
  assign lower_blue_o   = lo_bits_q[2];
  assign shift_column_o = shift_col_q;
  assign latch_last_o   = last_q;
  assign row_address_o  = row_addr_q;

endmodule

// ===== rtl/hub75_row_scan_pwm_driver.sv =====
// Top level of the split-scan row driver: pixel writes plus per-row threshold scan-out.
// A tick sends the control to the scan state, which reads both frame store halves
// per column; beats pass the read stage and the output register, one beat per cycle
// while the output is ready. The next item is taken once the last column has left
// the read stage. After reset a pass zeroes 16 * 2**ceil(log2(PANEL_WIDTH)) addresses
// (1024 at 64 columns); no item is accepted until it finishes.
`timescale 1ns / 1ps
module hub75_row_scan_pwm_driver
  import hrs_pkg::*;
#(
  parameter int unsigned PANEL_WIDTH = 64
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  hrs_in_if.sink    in_i,
  hrs_out_if.source out_o
);

  ctrl_cmd_t  cmd;
  dp_status_t status;
  logic       in_ready;

  hrs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_action_i (in_i.action),
    .in_ready_o  (in_ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  assign in_i.ready = in_ready;

  hrs_dpath #(.PANEL_WIDTH(PANEL_WIDTH)) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .column_i       (in_i.column),
    .row_i          (in_i.row),
    .pixel_color_i  (in_i.pixel_color),
    .out_ready_i    (out_o.ready),
    .out_valid_o    (out_o.valid),
    .upper_red_o    (out_o.upper_red),
    .upper_green_o  (out_o.upper_green),
    .upper_blue_o   (out_o.upper_blue),
    .lower_red_o    (out_o.lower_red),
    .lower_green_o  (out_o.lower_green),
    .lower_blue_o   (out_o.lower_blue),
    .shift_column_o (out_o.shift_column),
    .latch_last_o   (out_o.latch_last),
    .row_address_o  (out_o.row_address)
  );

  // no input beat while columns are still being read
  a_no_accept_while_issue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd.issue && in_ready))
    else $error("input accepted during column issue");

  // the clearing pass never overlaps an accepted beat
  a_no_accept_while_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd.clr_en && in_i.valid && in_ready))
    else $error("input accepted during frame store clear");

  // the latch beat always carries the last column
  a_latch_on_last_col: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.latch_last) |-> (out_o.shift_column == COL_W'(PANEL_WIDTH - 1)))
    else $error("latch beat not on last column");

  // row address is zero off the latch beat
  a_row_addr_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.latch_last) |-> (out_o.row_address == '0))
    else $error("row address nonzero before latch");

endmodule

// ===== tb/hrs_scan_checker.sv =====
// scoreboard for the row scan driver: shadow frame store, scan-out prediction, beat compare
`timescale 1ns / 1ps
module hrs_scan_checker
  import hrs_pkg::*;
#(
  parameter int unsigned PANEL_WIDTH = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  hrs_in_if           pix_mon,
  hrs_out_if          col_mon,
  output int unsigned mismatch_cnt_o,
  output int unsigned beats_due_o,
  output int unsigned writes_o,
  output int unsigned ticks_o,
  output int unsigned beats_o
);

  localparam int unsigned STORE_DEPTH = 2048;
  localparam int unsigned PANEL_ROWS  = 32;
  localparam int unsigned ROW_SPLIT   = 16;

  localparam logic [SCAN_ROW_W-1:0] ROW_AT_RESET   = 4'd15;
  localparam logic [CH_W-1:0]       PLANE_AT_RESET = 5'd30;
  localparam logic [CH_W-1:0]       PLANE_MAX      = 5'd30;

  typedef struct packed {
    logic                  upper_red;
    logic                  upper_green;
    logic                  upper_blue;
    logic                  lower_red;
    logic                  lower_green;
    logic                  lower_blue;
    logic [COL_W-1:0]      shift_column;
    logic                  latch_last;
    logic [SCAN_ROW_W-1:0] row_address;
  } col_beat_t;

  logic [COLOR_W-1:0]    pixel_shadow [STORE_DEPTH];
  logic [SCAN_ROW_W-1:0] cur_row;
  logic [CH_W-1:0]       cur_plane;
  col_beat_t             column_beats_due [$];
  int unsigned           n_mismatch;
  int unsigned           n_writes;
  int unsigned           n_ticks;
  int unsigned           n_beats;

  // dimming threshold is the plane counter read back to front
  function automatic logic [CH_W-1:0] plane_threshold(input logic [CH_W-1:0] plane);
    logic [CH_W-1:0] thr;
    for (int i = 0; i < CH_W; i++) thr[i] = plane[CH_W-1-i];
    return thr;
  endfunction

  function automatic logic [COLOR_W-1:0] shadow_pixel(input int unsigned col,
                                                      input int unsigned row);
    int unsigned idx;
    idx = col + row * PANEL_WIDTH;
    if (idx >= STORE_DEPTH) return '0;
    return pixel_shadow[idx];
  endfunction

  task automatic store_pixel(input logic [COL_W-1:0] col, input logic [ROW_W-1:0] row,
                             input logic [COLOR_W-1:0] color);
    int unsigned idx;
    idx = col + row * PANEL_WIDTH;
    if (col < PANEL_WIDTH && row < PANEL_ROWS && idx < STORE_DEPTH) pixel_shadow[idx] = color;
  endtask

  task automatic predict_row_scan();
    logic [CH_W-1:0]    thr;
    logic [COLOR_W-1:0] up;
    logic [COLOR_W-1:0] lo;
    col_beat_t          beat;
    cur_row = cur_row + 1'b1;
    if (cur_row == '0) cur_plane = (cur_plane == PLANE_MAX) ? '0 : cur_plane + 1'b1;
    thr = plane_threshold(cur_plane);
    for (int x = 0; x < PANEL_WIDTH; x++) begin
      up = shadow_pixel(x, 32'(cur_row));
      lo = shadow_pixel(x, 32'(cur_row) + ROW_SPLIT);
      beat.upper_red    = up[4:0] > thr;
      beat.upper_green  = up[9:5] > thr;
      beat.upper_blue   = up[14:10] > thr;
      beat.lower_red    = lo[4:0] > thr;
      beat.lower_green  = lo[9:5] > thr;
      beat.lower_blue   = lo[14:10] > thr;
      beat.shift_column = x[COL_W-1:0];
      beat.latch_last   = (x == PANEL_WIDTH - 1);
      beat.row_address  = beat.latch_last ? cur_row : '0;
      column_beats_due.push_back(beat);
    end
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      n_mismatch++;
    end
  endtask

  task automatic compare_beat();
    col_beat_t want;
    if (column_beats_due.size() == 0) begin
      $error("column beat for column %0d with nothing expected", col_mon.shift_column);
      n_mismatch++;
    end else begin
      want = column_beats_due.pop_front();
      n_beats++;
      check_field("upper_red", 32'(want.upper_red), 32'(col_mon.upper_red));
      check_field("upper_green", 32'(want.upper_green), 32'(col_mon.upper_green));
      check_field("upper_blue", 32'(want.upper_blue), 32'(col_mon.upper_blue));
      check_field("lower_red", 32'(want.lower_red), 32'(col_mon.lower_red));
      check_field("lower_green", 32'(want.lower_green), 32'(col_mon.lower_green));
      check_field("lower_blue", 32'(want.lower_blue), 32'(col_mon.lower_blue));
      check_field("shift_column", 32'(want.shift_column), 32'(col_mon.shift_column));
      check_field("latch_last", 32'(want.latch_last), 32'(col_mon.latch_last));
      check_field("row_address", 32'(want.row_address), 32'(col_mon.row_address));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < STORE_DEPTH; i++) pixel_shadow[i] = '0;
      cur_row    = ROW_AT_RESET;
      cur_plane  = PLANE_AT_RESET;
      column_beats_due.delete();
      n_mismatch = 0;
      n_writes   = 0;
      n_ticks    = 0;
      n_beats    = 0;
    end else begin
      if (pix_mon.valid && pix_mon.ready) begin
        if (pix_mon.action == ACT_TICK) begin
          n_ticks++;
          predict_row_scan();
        end else begin
          n_writes++;
          store_pixel(pix_mon.column, pix_mon.row, pix_mon.pixel_color);
        end
      end
      if (col_mon.valid && col_mon.ready) compare_beat();
    end
    // published after the edge so the stimulus side reads settled values
    mismatch_cnt_o <= n_mismatch;
    beats_due_o    <= column_beats_due.size();
    writes_o       <= n_writes;
    ticks_o        <= n_ticks;
    beats_o        <= n_beats;
  end

endmodule

// ===== tb/tb_hub75_row_scan_pwm_driver.sv =====
// testbench top for the row scan driver: pixel/tick stimulus, output stalls, verdict
`timescale 1ns / 1ps
module tb_hub75_row_scan_pwm_driver;
  import hrs_pkg::*;

  localparam int unsigned PANEL_WIDTH = 64;
  localparam int unsigned N_RANDOM    = 370;
  // covers the clear after reset plus the longest gap and stall
  localparam int unsigned QUIET_LIMIT = 4000;
  localparam int unsigned DRAIN_WAIT  = 80;

  logic        clk_i;
  logic        rst_ni;
  logic        calm;
  int unsigned ticks_sent;
  int unsigned items_sent;
  int unsigned ready_hold;
  int unsigned stall;
  int unsigned mismatch_cnt;
  int unsigned beats_due;
  int unsigned writes_seen;
  int unsigned ticks_seen;
  int unsigned beats_seen;

  hrs_in_if  pix_if ();
  hrs_out_if col_if ();

  hub75_row_scan_pwm_driver #(
    .PANEL_WIDTH (PANEL_WIDTH)
  ) u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (pix_if),
    .out_o  (col_if)
  );

  hrs_scan_checker #(
    .PANEL_WIDTH (PANEL_WIDTH)
  ) u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .pix_mon        (pix_if),
    .col_mon        (col_if),
    .mismatch_cnt_o (mismatch_cnt),
    .beats_due_o    (beats_due),
    .writes_o       (writes_seen),
    .ticks_o        (ticks_seen),
    .beats_o        (beats_seen)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // output side: after each taken beat draw a random stall and hold ready low for it, unless calm
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      col_if.ready <= 1'b0;
      ready_hold   <= 0;
    end else begin
      if (col_if.ready) begin
        if (col_if.valid) begin
          stall = calm ? 0 : $urandom_range(0, 7);
          if (stall != 0) begin
            col_if.ready <= 1'b0;
            ready_hold   <= stall;
          end
        end
      end else if (ready_hold <= 1) begin
        col_if.ready <= 1'b1;
        ready_hold   <= 0;
      end else begin
        ready_hold <= ready_hold - 1;
      end
    end
  end

  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((pix_if.valid && pix_if.ready) || (col_if.valid && col_if.ready)) quiet = 0;
      else quiet++;
    end
    $display("watchdog: no beat moved for %0d cycles", QUIET_LIMIT);
    $display("*** FAILED ***");
    $finish;
  end

  // valid stays high across back-to-back items, it only drops when a gap is drawn
  task automatic send_item(input logic act, input logic [COL_W-1:0] col,
                           input logic [ROW_W-1:0] row, input logic [COLOR_W-1:0] color);
    int unsigned gap;
    gap = calm ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      pix_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    pix_if.valid       <= 1'b1;
    pix_if.action      <= act;
    pix_if.column      <= col;
    pix_if.row         <= row;
    pix_if.pixel_color <= color;
    @(posedge clk_i);
    while (!pix_if.ready) @(posedge clk_i);
    items_sent++;
    if (act == ACT_TICK) ticks_sent++;
  endtask

  task automatic send_tick();
    send_item(ACT_TICK, COL_W'($urandom_range(0, 63)), ROW_W'($urandom_range(0, 31)),
              COLOR_W'($urandom_range(0, 32767)));
  endtask

  function automatic logic [CH_W-1:0] pick_level();
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return '1;
      default: return CH_W'($urandom_range(0, 31));
    endcase
  endfunction

  initial begin
    logic [ROW_W-1:0] wr_row;
    int unsigned      n_writes;
    pix_if.valid       = 1'b0;
    pix_if.action      = ACT_WRITE;
    pix_if.column      = '0;
    pix_if.row         = '0;
    pix_if.pixel_color = '0;
    calm               = 1'b0;
    ticks_sent         = 0;
    items_sent         = 0;
    rst_ni             = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // first tick wraps the plane counter from its reset value back to zero
    send_tick();
    // row 1 and its lower partner row 17: full white, single channels, level one
    send_item(ACT_WRITE, 6'd0, 5'd1, 15'h7fff);
    send_item(ACT_WRITE, 6'd63, 5'd17, 15'h7fff);
    send_item(ACT_WRITE, 6'd63, 5'd1, 15'h001f);
    send_item(ACT_WRITE, 6'd0, 5'd17, 15'h03e0);
    send_item(ACT_WRITE, 6'd1, 5'd1, 15'h7c00);
    send_item(ACT_WRITE, 6'd1, 5'd17, 15'h0001);
    send_item(ACT_WRITE, 6'd2, 5'd1, 15'h0421);
    send_tick();
    // edge rows, and an overwrite of one pixel
    send_item(ACT_WRITE, 6'd5, 5'd15, 15'h7fff);
    send_item(ACT_WRITE, 6'd6, 5'd31, 15'h5555);
    send_item(ACT_WRITE, 6'd0, 5'd0, 15'h7fff);
    send_item(ACT_WRITE, 6'd0, 5'd0, 15'h0000);
    send_item(ACT_WRITE, 6'd63, 5'd16, 15'h2aaa);
    send_tick();

    // rounds of a few writes aimed at the next row pair, then the tick that shows them
    while (items_sent < N_RANDOM) begin
      if (items_sent % 40 < 4) calm = ($urandom_range(0, 3) == 0);
      n_writes = $urandom_range(0, 4);
      for (int i = 0; i < n_writes; i++) begin
        if ($urandom_range(0, 3) != 0) begin
          wr_row = {1'($urandom_range(0, 1)), 4'(ticks_sent % 16)};
        end else begin
          wr_row = ROW_W'($urandom_range(0, 31));
        end
        send_item(ACT_WRITE, COL_W'($urandom_range(0, 63)), wr_row,
                  {pick_level(), pick_level(), pick_level()});
      end
      send_tick();
    end
    pix_if.valid <= 1'b0;

    @(posedge clk_i);
    while (beats_due != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    $display("run: %0d pixel writes and %0d row ticks, %0d column beats compared",
             writes_seen, ticks_seen, beats_seen);
    $display("run: %0d full frames scanned, dimming planes 0 to %0d reached",
             ticks_seen / 16, (ticks_seen - 1) / 16);
    if (mismatch_cnt == 0 && beats_due == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
